>>> rtl/mgrs_pkg.sv
package mgrs_pkg;

    // One request: a node of the graph in topological order.
    typedef struct packed {
        logic        kind;
        logic [11:0] node_id;
        logic [11:0] fanin_a;
        logic        fanin_a_inv;
        logic [11:0] fanin_b;
        logic        fanin_b_inv;
        logic [11:0] fanin_c;
        logic        fanin_c_inv;
    } t_mgrs_in;

    // One result: the node's simulation word and its bucket key.
    typedef struct packed {
        logic [11:0] out_node;
        logic [31:0] sim_word;
        logic [15:0] bucket_key;
    } t_mgrs_out;

    localparam int unsigned TS_W   = 17;
    localparam int unsigned IDX_W  = 12;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KEY_W  = 16;
    localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

    localparam logic [TS_W-1:0]   TS_RESET = 17'd1024;
    localparam logic [TS_W-1:0]   TS_MAX   = 17'd65536;
    localparam logic [TS_W-1:0]   TS_MIN   = 17'd1;

    localparam logic [WORD_W-1:0] GEN_HIGH_SEED = 32'd3716960521;
    localparam logic [WORD_W-1:0] GEN_LOW_SEED  = 32'd2174103536;
    localparam logic [WORD_W-1:0] GEN_HIGH_MUL  = 32'd36969;
    localparam logic [WORD_W-1:0] GEN_LOW_MUL   = 32'd18000;

    localparam logic        KIND_INPUT = 1'b0;
    localparam logic        KIND_GATE  = 1'b1;

    typedef enum logic [1:0] {
        FANIN_A,
        FANIN_B,
        FANIN_C
    } t_mgrs_fanin;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        gen_step;
        logic        rd_en;
        t_mgrs_fanin rd_sel;
        logic        cap;
        logic        word_ld;
        logic        div_step;
        logic        fin;
    } t_mgrs_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic div_last;
        logic out_free;
    } t_mgrs_sts;

endpackage

>>> rtl/majority_graph_random_simulator.sv
// Bit-parallel random simulator for a majority-inverter graph, 32 patterns per
// node. Requests describe nodes in topological order. A primary-input request
// stores the next word of a two-lane multiply-with-carry generator; a gate
// request reads its three fanins from the value store (node 0 always reads as
// all ones, a set complement bit inverts), stores their bitwise majority and
// returns it with a bucket key, the word modulo the configured table size
// (0 acts as 1, values above 65536 act as 65536; the key is 0 for primary
// inputs). One request is worked on at a time. A gate passes through three
// reads via the single registered port of the value store, the forming of
// the word, the bit-serial remainder unit and the hand-over to the result
// register; a primary input takes a generator step instead of the reads and
// the remainder unit. The result register lets the next request be accepted
// while the previous result still waits. Store entries must be written before
// they are read; there is no clearing pass after reset.
module majority_graph_random_simulator #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  mgrs_pkg::t_mgrs_in        i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mgrs_pkg::t_mgrs_out       o_out_rsp,
    input  logic                      i_cfg_we,
    input  logic [mgrs_pkg::TS_W-1:0] i_cfg_wdata
);
    import mgrs_pkg::*;

    // Command and status groups between the sequencer and the datapath.
    t_mgrs_cmd cmd;
    t_mgrs_sts sts;

    // The controller steps each request through its reads, the word update,
    // the remainder iterations and the hand-over to the result register.
    mgrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the value store, the generator, the table size
    // register, the serial remainder unit and the result register.
    mgrs_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> rtl/mgrs_ctrl.sv
module mgrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mgrs_pkg::t_mgrs_sts i_sts,
    output mgrs_pkg::t_mgrs_cmd o_cmd
);
    import mgrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEN,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_RD_W,
        S_WORD,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RD_A;
                end
            end
            S_GEN: begin
                o_cmd.gen_step = 1'b1;
                n_state        = S_WORD;
            end
            S_RD_A: begin
                // The kind is known only once the request has been latched.
                if (i_sts.kind == KIND_INPUT) begin
                    n_state = S_GEN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = FANIN_A;
                    n_state      = S_RD_B;
                end
            end
            S_RD_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = FANIN_B;
                o_cmd.cap    = 1'b1;
                n_state      = S_RD_C;
            end
            S_RD_C: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = FANIN_C;
                o_cmd.cap    = 1'b1;
                n_state      = S_RD_W;
            end
            S_RD_W: begin
                o_cmd.cap = 1'b1;
                n_state   = S_WORD;
            end
            S_WORD: begin
                o_cmd.word_ld = 1'b1;
                n_state       = (i_sts.kind == KIND_GATE) ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/mgrs_dp.sv
module mgrs_dp #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mgrs_pkg::t_mgrs_in              i_in_req,
    input  logic                            i_cfg_we,
    input  logic [mgrs_pkg::TS_W-1:0]       i_cfg_wdata,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output mgrs_pkg::t_mgrs_out             o_out_rsp,
    input  mgrs_pkg::t_mgrs_cmd             i_cmd,
    output mgrs_pkg::t_mgrs_sts             o_sts
);
    import mgrs_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);

    // Request, configuration and generator state.
    t_mgrs_in            r_req;
    logic [TS_W-1:0]     r_table_size;
    logic [WORD_W-1:0]   r_gen_high;
    logic [WORD_W-1:0]   r_gen_low;

    // Value store with one registered read port.
    logic [WORD_W-1:0]   r_mem [NODE_COUNT];
    logic [WORD_W-1:0]   r_rd_q;
    logic                r_rd_one;
    logic                r_rd_zero;
    logic                r_rd_inv;

    // Fanin values; order is irrelevant since majority is symmetric.
    logic [WORD_W-1:0]   r_fa;
    logic [WORD_W-1:0]   r_fb;
    logic [WORD_W-1:0]   r_fc;

    logic [WORD_W-1:0]   r_word;
    logic [WORD_W-1:0]   r_dvd;
    logic [TS_W-1:0]     r_rem;
    logic [TS_W-1:0]     r_div_ts;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic                r_out_valid;
    t_mgrs_out           r_out;

    logic [IDX_W-1:0]    rd_idx;
    logic                rd_inv;
    logic [WORD_W-1:0]   fanin_val;
    logic [WORD_W-1:0]   maj_word;
    logic [WORD_W-1:0]   rnd_word;
    logic [WORD_W-1:0]   n_word;
    logic [WORD_W-1:0]   n_gen_high;
    logic [WORD_W-1:0]   n_gen_low;
    logic [TS_W-1:0]     ts_clamped;
    logic [TS_W:0]       rem_sh;
    logic [TS_W:0]       rem_sub;
    logic                wr_ok;

    always_comb begin
        rd_idx = r_req.fanin_a;
        rd_inv = r_req.fanin_a_inv;
        unique case (i_cmd.rd_sel)
            FANIN_A: begin
                rd_idx = r_req.fanin_a;
                rd_inv = r_req.fanin_a_inv;
            end
            FANIN_B: begin
                rd_idx = r_req.fanin_b;
                rd_inv = r_req.fanin_b_inv;
            end
            FANIN_C: begin
                rd_idx = r_req.fanin_c;
                rd_inv = r_req.fanin_c_inv;
            end
            default: begin
                rd_idx = r_req.fanin_a;
                rd_inv = r_req.fanin_a_inv;
            end
        endcase
    end

    always_comb begin
        if (r_rd_one) begin
            fanin_val = '1;
        end else if (r_rd_zero) begin
            fanin_val = '0;
        end else begin
            fanin_val = r_rd_q;
        end
        if (r_rd_inv) begin
            fanin_val = ~fanin_val;
        end
    end

    assign maj_word   = (r_fa & r_fb) | (r_fa & r_fc) | (r_fb & r_fc);
    assign rnd_word   = {r_gen_high[15:0], 16'd0} + r_gen_low;
    assign n_word     = (r_req.kind == KIND_GATE) ? maj_word : rnd_word;
    assign n_gen_high = WORD_W'(r_gen_high[15:0]) * GEN_HIGH_MUL
                      + WORD_W'(r_gen_high[31:16]);
    assign n_gen_low  = WORD_W'(r_gen_low[15:0]) * GEN_LOW_MUL
                      + WORD_W'(r_gen_low[31:16]);

    always_comb begin
        if (r_table_size == '0) begin
            ts_clamped = TS_MIN;
        end else if (r_table_size > TS_MAX) begin
            ts_clamped = TS_MAX;
        end else begin
            ts_clamped = r_table_size;
        end
    end

    // One restoring division step per cycle, most significant bit first.
    assign rem_sh  = {r_rem, r_dvd[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div_ts};

    assign wr_ok = (r_req.node_id != '0) && (32'(r_req.node_id) < NODE_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.rd_en) begin
            r_rd_q    <= r_mem[AW'(rd_idx)];
            r_rd_one  <= (rd_idx == '0);
            r_rd_zero <= !(32'(rd_idx) < NODE_COUNT);
            r_rd_inv  <= rd_inv;
        end
        if (i_cmd.cap) begin
            r_fa <= fanin_val;
            r_fb <= r_fa;
            r_fc <= r_fb;
        end
        if (i_cmd.word_ld) begin
            r_word   <= n_word;
            r_dvd    <= n_word;
            r_rem    <= '0;
            r_div_ts <= ts_clamped;
            r_cnt    <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (rem_sh >= {1'b0, r_div_ts}) begin
                r_rem <= TS_W'(rem_sub);
            end else begin
                r_rem <= TS_W'(rem_sh);
            end
        end
        if (i_cmd.fin) begin
            if (wr_ok) begin
                r_mem[AW'(r_req.node_id)] <= r_word;
            end
            r_out.out_node   <= r_req.node_id;
            r_out.sim_word   <= r_word;
            r_out.bucket_key <= KEY_W'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_RESET;
            r_gen_high   <= GEN_HIGH_SEED;
            r_gen_low    <= GEN_LOW_SEED;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (i_cmd.gen_step) begin
                r_gen_high <= n_gen_high;
                r_gen_low  <= n_gen_low;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind     = r_req.kind;
    assign o_sts.div_last = (r_cnt == '1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

>>> tb/mgrs_result_checker.sv
module mgrs_result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  mgrs_pkg::t_mgrs_in        i_in_req,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  mgrs_pkg::t_mgrs_out       i_out_rsp,
    input  logic                      i_cfg_we,
    input  logic [mgrs_pkg::TS_W-1:0] i_cfg_wdata,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_fail_count
);
    import mgrs_pkg::*;

    localparam logic [31:0]   HIGH_LANE_START  = 32'd3716960521;
    localparam logic [31:0]   LOW_LANE_START   = 32'd2174103536;
    localparam logic [31:0]   HIGH_LANE_MUL    = 32'd36969;
    localparam logic [31:0]   LOW_LANE_MUL     = 32'd18000;
    localparam logic [TS_W-1:0] BUCKETS_AT_RESET = 17'd1024;
    localparam logic [TS_W-1:0] BUCKETS_CEILING  = 17'd65536;
    localparam int            MAX_REPORTS      = 40;

    logic [31:0]     node_words [4096];
    logic [31:0]     lane_hi = HIGH_LANE_START;
    logic [31:0]     lane_lo = LOW_LANE_START;
    logic [TS_W-1:0] buckets = BUCKETS_AT_RESET;
    t_mgrs_out       sim_results_due [$];
    t_mgrs_out       oldest;
    int              checked = 0;
    int              fails   = 0;

    // Node 0 is the constant node and always reads as all ones.
    function automatic logic [31:0] fanin_word(logic [11:0] idx, logic inv);
        logic [31:0] w;
        w = (idx == 12'd0) ? 32'hFFFF_FFFF : node_words[idx];
        return inv ? ~w : w;
    endfunction

    function automatic t_mgrs_out simulate_node(t_mgrs_in req);
        t_mgrs_out   res;
        logic [31:0] a, b, c, word, divisor;
        res = '0;
        if (req.kind == KIND_INPUT) begin
            lane_hi = HIGH_LANE_MUL * {16'h0, lane_hi[15:0]} + {16'h0, lane_hi[31:16]};
            lane_lo = LOW_LANE_MUL * {16'h0, lane_lo[15:0]} + {16'h0, lane_lo[31:16]};
            word = {lane_hi[15:0], 16'h0} + lane_lo;
        end else begin
            a = fanin_word(req.fanin_a, req.fanin_a_inv);
            b = fanin_word(req.fanin_b, req.fanin_b_inv);
            c = fanin_word(req.fanin_c, req.fanin_c_inv);
            word = (a & b) | (a & c) | (b & c);
            // A table size of zero behaves as one; anything larger than the
            // ceiling is clamped to it.
            if (buckets == '0) begin
                divisor = 32'd1;
            end else if (buckets > BUCKETS_CEILING) begin
                divisor = 32'(BUCKETS_CEILING);
            end else begin
                divisor = 32'(buckets);
            end
            res.bucket_key = 16'(word % divisor);
        end
        if (req.node_id != 12'd0) begin
            node_words[req.node_id] = word;
        end
        res.out_node = req.node_id;
        res.sim_word = word;
        return res;
    endfunction

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lane_hi = HIGH_LANE_START;
            lane_lo = LOW_LANE_START;
            buckets = BUCKETS_AT_RESET;
            sim_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                buckets = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (sim_results_due.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, i_out_rsp);
                    end
                end else begin
                    oldest = sim_results_due.pop_front();
                    checked++;
                    if (i_out_rsp.out_node !== oldest.out_node) begin
                        report_field("out_node", 32'(oldest.out_node),
                                     32'(i_out_rsp.out_node));
                    end
                    if (i_out_rsp.sim_word !== oldest.sim_word) begin
                        report_field("sim_word", oldest.sim_word, i_out_rsp.sim_word);
                    end
                    if (i_out_rsp.bucket_key !== oldest.bucket_key) begin
                        report_field("bucket_key", 32'(oldest.bucket_key),
                                     32'(i_out_rsp.bucket_key));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                sim_results_due.push_back(simulate_node(i_in_req));
            end
        end
        o_pending    <= sim_results_due.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_majority_graph_random_simulator.sv
// Testbench for the majority-graph random simulator. The top level only makes
// stimulus and gives the verdict; the checker beside the block watches both
// channels and the configuration port, predicts each result and compares it.
module tb_majority_graph_random_simulator;
    import mgrs_pkg::*;

    // Random requests are spread evenly over the table-size phases.
    localparam int PHASES         = 10;
    localparam int RANDOM_NODES   = 1150;
    localparam int NODES_PER_PHASE = RANDOM_NODES / PHASES;
    // Generous ceiling on the run: far beyond the slowest correct run.
    localparam int RUN_LIMIT      = 10_000_000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_mgrs_in        i_in_req;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_mgrs_out       o_out_rsp;
    logic            i_cfg_we;
    logic [TS_W-1:0] i_cfg_wdata;

    int pending;
    int checked;
    int fail_count;

    // Bookkeeping of the stimulus side: which store entries hold a value, so
    // that a gate only ever reads nodes that have been written.
    bit          written_map [4096];
    logic [11:0] written_ids [$];
    logic [11:0] recent_ids [$];
    int          quiet_left = 0;
    int          gates_sent = 0;
    int          inputs_sent = 0;
    int          tables_used = 1;
    int unsigned rdy_hold = 0;
    int unsigned rdy_roll;

    majority_graph_random_simulator #(
        .NODE_COUNT (4096)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mgrs_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_rsp    (o_out_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("majority_graph_random_simulator test failed");
        $finish;
    end

    // The result side holds ready high or low for runs of random length. Most
    // runs are short, a few stalls are long, and now and then a long stretch
    // passes with no stall at all, so that back-pressure lands on every stage
    // of the block's work.
    always @(posedge i_clk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 50) begin
                i_out_ready <= 1'b1;
                rdy_hold    <= $urandom_range(1, 12);
            end else if (rdy_roll < 60) begin
                i_out_ready <= 1'b1;
                rdy_hold    <= $urandom_range(100, 300);
            end else if (rdy_roll < 90) begin
                i_out_ready <= 1'b0;
                rdy_hold    <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                rdy_hold    <= $urandom_range(8, 70);
            end
        end
    end

    // Idle cycles before the next request. Mostly none or a few, sometimes a
    // long pause, and occasionally a stretch of back-to-back requests.
    function automatic int next_gap();
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic t_mgrs_in node_req(logic kind, int node, int fa, logic fai,
                                          int fb, logic fbi, int fc, logic fci);
        t_mgrs_in req;
        req.kind        = kind;
        req.node_id     = 12'(node);
        req.fanin_a     = 12'(fa);
        req.fanin_a_inv = fai;
        req.fanin_b     = 12'(fb);
        req.fanin_b_inv = fbi;
        req.fanin_c     = 12'(fc);
        req.fanin_c_inv = fci;
        return req;
    endfunction

    // A fanin is the constant node, one of the most recently written nodes
    // (which builds deep chains of gates), or any node written so far.
    function automatic logic [11:0] pick_fanin();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10 || written_ids.size() == 0) begin
            return 12'd0;
        end
        if (roll < 55) begin
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        end
        return written_ids[$urandom_range(0, written_ids.size() - 1)];
    endfunction

    // Most requests are well formed: a primary input or a gate whose fanins
    // are all written. The rest are primary inputs with every field filled
    // with random bits, since the fanins of a primary input are never read.
    function automatic t_mgrs_in random_node();
        t_mgrs_in    req;
        logic [63:0] noise;
        if ($urandom_range(0, 99) < 12) begin
            noise    = {$urandom, $urandom};
            req      = noise[$bits(t_mgrs_in)-1:0];
            req.kind = KIND_INPUT;
        end else begin
            req.kind        = ($urandom_range(0, 99) < 35) ? KIND_INPUT : KIND_GATE;
            req.node_id     = ($urandom_range(0, 99) < 3) ? 12'd0
                                                          : 12'($urandom_range(1, 4095));
            req.fanin_a     = pick_fanin();
            req.fanin_a_inv = 1'($urandom_range(0, 1));
            req.fanin_b     = pick_fanin();
            req.fanin_b_inv = 1'($urandom_range(0, 1));
            req.fanin_c     = pick_fanin();
            req.fanin_c_inv = 1'($urandom_range(0, 1));
        end
        return req;
    endfunction

    // Offers one request after a random gap and returns once it is accepted.
    // Valid stays high with the payload unchanged until the handshake.
    task automatic drive_node(input t_mgrs_in req);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req.kind == KIND_GATE) begin
            gates_sent++;
        end else begin
            inputs_sent++;
        end
        // Writes to the constant node are dropped by the block.
        if (req.node_id != 12'd0) begin
            if (!written_map[req.node_id]) begin
                written_map[req.node_id] = 1'b1;
                written_ids.push_back(req.node_id);
            end
            recent_ids.push_back(req.node_id);
            if (recent_ids.size() > 16) begin
                void'(recent_ids.pop_front());
            end
        end
    endtask

    // Stops offering requests and waits until every predicted result has
    // been taken. The block handles one request at a time and every request
    // gives a result, so it is idle from then on.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [TS_W-1:0] entries;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the table size left by reset. Primary inputs
        // with field extremes, an attempt to overwrite the constant node from
        // both kinds of request, gates built from the constant node alone,
        // complemented pairs that cancel, and a gate reading its own node.
        drive_node(node_req(KIND_INPUT, 1, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_INPUT, 4095, 4095, 1, 4095, 1, 4095, 1));
        drive_node(node_req(KIND_INPUT, 2, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_INPUT, 0, 1, 0, 2, 0, 3, 1));
        drive_node(node_req(KIND_GATE, 3, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_GATE, 4, 0, 1, 0, 1, 0, 1));
        drive_node(node_req(KIND_GATE, 5, 0, 0, 0, 1, 1, 0));
        drive_node(node_req(KIND_GATE, 6, 1, 1, 2, 1, 4095, 1));
        drive_node(node_req(KIND_GATE, 0, 1, 0, 2, 0, 4095, 0));
        drive_node(node_req(KIND_GATE, 7, 0, 0, 0, 0, 1, 1));
        drive_node(node_req(KIND_GATE, 4095, 4095, 0, 1, 1, 2, 0));
        drive_node(node_req(KIND_GATE, 8, 4095, 1, 4095, 0, 3, 0));
        drive_node(node_req(KIND_INPUT, 2048, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_INPUT, 1365, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_INPUT, 2730, 0, 0, 0, 0, 0, 0));
        drive_node(node_req(KIND_GATE, 9, 2048, 0, 1365, 1, 2730, 0));
        drive_node(node_req(KIND_GATE, 10, 4, 0, 4, 0, 3, 0));

        // Random part, one phase per table size. The sizes include the
        // smallest and largest legal ones, zero (which acts as one) and the
        // all-ones register value (which saturates).
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                case (phase)
                    1:       entries = 17'd1;
                    2:       entries = 17'd65536;
                    3:       entries = 17'd0;
                    4:       entries = 17'h1FFFF;
                    5:       entries = 17'd65535;
                    6:       entries = 17'd3;
                    7:       entries = 17'd1000;
                    default: entries = 17'($urandom_range(2, 70000));
                endcase
                drain_results();
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= entries;
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                tables_used++;
            end
            for (int n = 0; n < NODES_PER_PHASE; n++) begin
                drive_node(random_node());
            end
        end

        // Wait for the last results, then a further window in which any
        // stray result would be caught.
        drain_results();
        repeat (60) @(posedge i_clk);

        $display("Covered %0d node requests (%0d gates, %0d primary inputs) under %0d table sizes.",
                 gates_sent + inputs_sent, gates_sent, inputs_sent, tables_used);
        $display("%0d results checked, %0d distinct store entries written.",
                 checked, written_ids.size());
        if (fail_count == 0) begin
            $display("majority_graph_random_simulator test passed");
        end else begin
            $display("majority_graph_random_simulator test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mgrs_pkg.sv
rtl/mgrs_ctrl.sv
rtl/mgrs_dp.sv
rtl/majority_graph_random_simulator.sv
tb/mgrs_result_checker.sv
tb/tb_majority_graph_random_simulator.sv
